>>> rtl/ostd_pkg.sv
// Shared types and constants for the opcode size table deframer.
// No dependencies; imported by ostd_lookup, ostd_parser and the top level.
package ostd_pkg;

	localparam int OPCODE_COUNT = 256;
	localparam int OPCODE_W     = 8;
	localparam int LEN_BYTES    = 4;
	localparam int OUT_LEN_W    = 32;

	typedef enum logic [2:0] {
		PH_OPCODE  = 3'b001,
		PH_LENGTH  = 3'b010,
		PH_PAYLOAD = 3'b100
	} ostd_phase_t;

	typedef enum logic [1:0] {
		ROLE_OPCODE  = 2'd0,
		ROLE_LENGTH  = 2'd1,
		ROLE_PAYLOAD = 2'd2,
		ROLE_DROPPED = 2'd3
	} ostd_role_t;

	typedef struct packed {
		logic                valid;
		logic [OPCODE_W-1:0] data;
	} ostd_item_t;

endpackage

>>> rtl/ostd_ram.sv
// Generic single write port RAM with registered read and read enable.
// No dependencies.
module ostd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/ostd_lookup.sv
// Input stage: size table RAM, entry valid bits and the stage 1 item register.
// Depends on ostd_pkg and ostd_ram.
module ostd_lookup
	import ostd_pkg::*;
#(
	parameter int SIZE_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  operation,
	input  logic [7:0]            data_byte,
	input  logic [7:0]            entry_index,
	input  logic [15:0]           entry_size,
	output ostd_item_t            item_s1,
	output logic [SIZE_WIDTH-1:0] size_s1,
	input  logic                  s1_ready
);

	logic                    accept;
	logic                    tbl_we;
	logic                    tbl_re;
	logic [SIZE_WIDTH-1:0]   rd_data;
	logic [OPCODE_COUNT-1:0] entry_valid_q;
	logic                    hit_s1;
	logic                    valid_s1;
	logic [OPCODE_W-1:0]     data_s1;

	assign in_stall = valid_s1 && !s1_ready;
	assign accept   = in_valid && !in_stall;
	assign tbl_we   = accept && operation;
	assign tbl_re   = accept && !operation;

	ostd_ram #(
		.WIDTH(SIZE_WIDTH),
		.DEPTH(OPCODE_COUNT)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(entry_index),
		.wdata(SIZE_WIDTH'(entry_size)),
		.re   (tbl_re),
		.raddr(data_byte),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
		end else if (tbl_we) begin
			entry_valid_q[entry_index] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= !operation;
		end else if (s1_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_re) begin
			data_s1 <= data_byte;
			hit_s1  <= entry_valid_q[data_byte];
		end
	end

	assign item_s1 = '{valid: valid_s1, data: data_s1};

	// unwritten entries read as unmapped
	assign size_s1 = hit_s1 ? rd_data : '0;

endmodule

>>> rtl/ostd_parser.sv
// Frame parser: phase state, length gather, byte counters and the result register.
// Depends on ostd_pkg.
module ostd_parser
	import ostd_pkg::*;
#(
	parameter int SIZE_WIDTH   = 16,
	parameter int LENGTH_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ostd_item_t            item_s1,
	input  logic [SIZE_WIDTH-1:0] size_s1,
	output logic                  s1_ready,
	input  logic [7:0]            var_opcode,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_byte,
	output logic [1:0]            byte_role,
	output logic [7:0]            frame_opcode,
	output logic [31:0]           payload_length,
	output logic                  frame_end
);

	localparam int PLEN_W = (SIZE_WIDTH > LENGTH_WIDTH) ? SIZE_WIDTH : LENGTH_WIDTH;

	ostd_phase_t             phase_q, phase_nxt;
	logic [7:0]              cur_op_q, cur_op_nxt;
	logic [LENGTH_WIDTH-1:0] gather_q, gather_nxt;
	logic [1:0]              lcount_q, lcount_nxt;
	logic [PLEN_W-1:0]       remain_q, remain_nxt;
	logic [PLEN_W-1:0]       plen_q, plen_nxt;

	logic                    take;
	logic [7:0]              b;
	logic [31:0]             gather_wide;
	logic [LENGTH_WIDTH-1:0] gathered;
	logic [PLEN_W-1:0]       remain_dec;
	logic [SIZE_WIDTH-1:0]   size_m1;

	ostd_role_t              o_role;
	logic [7:0]              o_op;
	logic [PLEN_W-1:0]       o_plen;
	logic                    o_end;

	logic                    out_valid_q;
	logic [7:0]              out_byte_q;
	ostd_role_t              out_role_q;
	logic [7:0]              out_op_q;
	logic [PLEN_W-1:0]       out_plen_q;
	logic                    out_end_q;

	assign s1_ready = !out_valid_q || !out_stall;
	assign take     = item_s1.valid && s1_ready;
	assign b        = item_s1.data;

	assign gather_wide = 32'(gather_q) | (32'(b) << {lcount_q, 3'b000});
	assign gathered    = gather_wide[LENGTH_WIDTH-1:0];
	assign remain_dec  = remain_q - PLEN_W'(1);
	assign size_m1     = size_s1 - SIZE_WIDTH'(1);

	always_comb begin
		phase_nxt  = phase_q;
		cur_op_nxt = cur_op_q;
		gather_nxt = gather_q;
		lcount_nxt = lcount_q;
		remain_nxt = remain_q;
		plen_nxt   = plen_q;
		o_role     = ROLE_OPCODE;
		o_op       = cur_op_q;
		o_plen     = '0;
		o_end      = 1'b0;
		unique case (phase_q)
			PH_LENGTH: begin
				o_role     = ROLE_LENGTH;
				gather_nxt = gathered;
				if (lcount_q != 2'(LEN_BYTES - 1)) begin
					lcount_nxt = lcount_q + 2'd1;
				end else begin
					lcount_nxt = '0;
					plen_nxt   = PLEN_W'(gathered);
					if (gathered == '0) begin
						phase_nxt = PH_OPCODE;
						o_end     = 1'b1;
					end else begin
						remain_nxt = PLEN_W'(gathered);
						phase_nxt  = PH_PAYLOAD;
						o_plen     = PLEN_W'(gathered);
					end
				end
			end
			PH_PAYLOAD: begin
				o_role     = ROLE_PAYLOAD;
				remain_nxt = remain_dec;
				o_plen     = plen_q;
				o_end      = (remain_dec == '0);
				if (remain_dec == '0) begin
					phase_nxt = PH_OPCODE;
				end
			end
			PH_OPCODE: begin
				o_op = b;
				if (size_s1 == '0) begin
					o_role = ROLE_DROPPED;
				end else begin
					cur_op_nxt = b;
					if (b == var_opcode) begin
						gather_nxt = '0;
						lcount_nxt = '0;
						plen_nxt   = '0;
						phase_nxt  = PH_LENGTH;
					end else begin
						plen_nxt = PLEN_W'(size_m1);
						if (size_m1 == '0) begin
							o_end = 1'b1;
						end else begin
							remain_nxt = PLEN_W'(size_m1);
							phase_nxt  = PH_PAYLOAD;
							o_plen     = PLEN_W'(size_m1);
						end
					end
				end
			end
			default: begin
				phase_nxt = PH_OPCODE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_OPCODE;
			cur_op_q <= '0;
			gather_q <= '0;
			lcount_q <= '0;
			remain_q <= '0;
			plen_q   <= '0;
		end else if (take) begin
			phase_q  <= phase_nxt;
			cur_op_q <= cur_op_nxt;
			gather_q <= gather_nxt;
			lcount_q <= lcount_nxt;
			remain_q <= remain_nxt;
			plen_q   <= plen_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_ready) begin
			out_valid_q <= item_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q <= b;
			out_role_q <= o_role;
			out_op_q   <= o_op;
			out_plen_q <= o_plen;
			out_end_q  <= o_end;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_byte       = out_byte_q;
	assign byte_role      = out_role_q;
	assign frame_opcode   = out_op_q;
	assign payload_length = OUT_LEN_W'(out_plen_q);
	assign frame_end      = out_end_q;

`ifndef SYNTHESIS
	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_LENGTH |-> lcount_q == '0)
		else $error("length byte count not clear outside length phase");

	a_remain_live: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> remain_q != '0)
		else $error("payload phase with nothing remaining");

	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_role_q == ROLE_DROPPED |-> !out_end_q && out_plen_q == '0)
		else $error("dropped opcode carries frame data");

	a_end_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		take && o_end |=> phase_q == PH_OPCODE)
		else $error("frame end without return to opcode phase");
`endif

endmodule

>>> rtl/opcode_size_table_deframer.sv
// Top level of the opcode size table deframer: variable opcode register,
// lookup stage and parser. Depends on ostd_pkg, ostd_lookup and ostd_parser.
//
// Input channel (in_valid / in_stall) carries one request per cycle while in_stall is low: either a
// stream byte (operation 0, data_byte) or a size table write (operation 1,
// entry_index, entry_size). Table writes produce no result and take effect
// for opcodes accepted after them.
// Output channel (out_valid / out_stall) carries one result per stream byte:
// the byte, its role, the frame opcode, payload length and frame end mark.
// Configuration channel (cfg_valid / cfg_ready) writes the variable opcode;
// cfg_ready is always high. Write it only while the block is idle.
// An accepted stream byte passes the table read register, then the result
// register, before it appears on the output. Throughput is one request per
// cycle while in_stall is low, set by the single table read port and the parse step.
// Reset clears every table entry to unmapped through per-entry valid bits,
// sets the variable opcode to 99 and returns the parser to expect an opcode;
// requests are accepted as soon as reset is released.
// While out_stall is high the result holds; one more byte may sit in the
// lookup stage, after which in_stall rises.
module opcode_size_table_deframer
	import ostd_pkg::*;
#(
	parameter int SIZE_WIDTH   = 16,
	parameter int LENGTH_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  variable_opcode,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  entry_index,
	input  logic [15:0] entry_size,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [1:0]  byte_role,
	output logic [7:0]  frame_opcode,
	output logic [31:0] payload_length,
	output logic        frame_end
);

	logic [7:0]            var_opcode_q;
	ostd_item_t            item_s1;
	logic [SIZE_WIDTH-1:0] size_s1;
	logic                  s1_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_opcode_q <= 8'd99;
		end else if (cfg_valid && cfg_ready) begin
			var_opcode_q <= variable_opcode;
		end
	end

	ostd_lookup #(
		.SIZE_WIDTH(SIZE_WIDTH)
	) u_lookup (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.data_byte  (data_byte),
		.entry_index(entry_index),
		.entry_size (entry_size),
		.item_s1    (item_s1),
		.size_s1    (size_s1),
		.s1_ready   (s1_ready)
	);

	ostd_parser #(
		.SIZE_WIDTH  (SIZE_WIDTH),
		.LENGTH_WIDTH(LENGTH_WIDTH)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_s1       (item_s1),
		.size_s1       (size_s1),
		.s1_ready      (s1_ready),
		.var_opcode    (var_opcode_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.byte_role     (byte_role),
		.frame_opcode  (frame_opcode),
		.payload_length(payload_length),
		.frame_end     (frame_end)
	);

endmodule

>>> tb/testbench.sv
// Self-checking bench for opcode_size_table_deframer: random and directed byte streams
// and size table writes, checked against a shadow parser kept in the bench.
// Depends on ostd_pkg and the deframer RTL only.
module testbench;
	import ostd_pkg::*;

	localparam bit       OP_STREAM        = 1'b0;
	localparam bit       OP_TABLE_WRITE   = 1'b1;
	localparam bit [7:0] VAR_OPCODE_RESET = 8'd99;
	localparam int       CYCLE_LIMIT      = 200000;
	localparam int       SHOWN_MISMATCHES = 10;
	localparam int       MODEL            = 0;
	localparam int       PLAN             = 1;

	typedef struct packed {
		bit        op;
		bit [7:0]  data;
		bit [7:0]  idx;
		bit [15:0] sz;
	} request_t;

	typedef struct packed {
		logic [7:0]  data;
		ostd_role_t  role;
		logic [7:0]  opcode;
		logic [31:0] plen;
		logic        eof;
	} frame_byte_t;

	typedef struct {
		bit [15:0]   size_tab [OPCODE_COUNT];
		ostd_phase_t phase;
		bit [7:0]    cur_op;
		bit [31:0]   gather;
		bit [1:0]    gcount;
		bit [31:0]   remaining;
		bit [31:0]   plen;
		bit [7:0]    var_op;
	} parser_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  variable_opcode = VAR_OPCODE_RESET;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        operation = OP_STREAM;
	logic [7:0]  data_byte = '0;
	logic [7:0]  entry_index = '0;
	logic [15:0] entry_size = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic [1:0]  byte_role;
	logic [7:0]  frame_opcode;
	logic [31:0] payload_length;
	logic        frame_end;

	parser_t     st [2];
	request_t    requests [$];
	frame_byte_t expected [$];
	bit          req_taken = 1'b0;
	bit          calm = 1'b0;
	int          cycles = 0;
	int          faults = 0;
	int          checked = 0;
	int          frames_closed = 0;
	int          dropped = 0;
	int          table_writes = 0;

	opcode_size_table_deframer u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.variable_opcode(variable_opcode),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.data_byte      (data_byte),
		.entry_index    (entry_index),
		.entry_size     (entry_size),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.byte_role      (byte_role),
		.frame_opcode   (frame_opcode),
		.payload_length (payload_length),
		.frame_end      (frame_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_parser(input int w);
		for (int i = 0; i < OPCODE_COUNT; i++)
			st[w].size_tab[i] = '0;
		st[w].phase     = PH_OPCODE;
		st[w].cur_op    = '0;
		st[w].gather    = '0;
		st[w].gcount    = '0;
		st[w].remaining = '0;
		st[w].plen      = '0;
		st[w].var_op    = VAR_OPCODE_RESET;
	endfunction

	// Advance one parser copy by a request; return 1 when it yields a result.
	function automatic bit deframe(input int w, input request_t r, output frame_byte_t f);
		f = '0;
		if (r.op == OP_TABLE_WRITE) begin
			st[w].size_tab[r.idx] = r.sz;
			return 1'b0;
		end
		f.data   = r.data;
		f.opcode = st[w].cur_op;
		case (st[w].phase)
			PH_LENGTH: begin
				f.role = ROLE_LENGTH;
				st[w].gather = st[w].gather | (32'(r.data) << (8 * st[w].gcount));
				if (st[w].gcount != 2'd3) begin
					st[w].gcount++;
				end else begin
					st[w].gcount = '0;
					st[w].plen   = st[w].gather;
					if (st[w].plen == 0) begin
						st[w].phase = PH_OPCODE;
						f.eof = 1'b1;
					end else begin
						st[w].remaining = st[w].plen;
						st[w].phase     = PH_PAYLOAD;
						f.plen          = st[w].plen;
					end
				end
			end
			PH_PAYLOAD: begin
				f.role = ROLE_PAYLOAD;
				f.plen = st[w].plen;
				st[w].remaining--;
				if (st[w].remaining == 0) begin
					st[w].phase = PH_OPCODE;
					f.eof = 1'b1;
				end
			end
			default: begin
				f.opcode = r.data;
				if (st[w].size_tab[r.data] == 0) begin
					f.role = ROLE_DROPPED;
				end else begin
					f.role       = ROLE_OPCODE;
					st[w].cur_op = r.data;
					if (r.data == st[w].var_op) begin
						st[w].gather = '0;
						st[w].gcount = '0;
						st[w].plen   = '0;
						st[w].phase  = PH_LENGTH;
					end else begin
						st[w].plen = 32'(st[w].size_tab[r.data]) - 32'd1;
						if (st[w].plen == 0) begin
							f.eof = 1'b1;
						end else begin
							st[w].remaining = st[w].plen;
							st[w].phase     = PH_PAYLOAD;
							f.plen          = st[w].plen;
						end
					end
				end
			end
		endcase
		return 1'b1;
	endfunction

	function automatic bit hold_off();
		return !calm && ($urandom_range(0, 99) < 14);
	endfunction

	function automatic void push(input request_t r);
		frame_byte_t unused;
		void'(deframe(PLAN, r, unused));
		requests.insert(requests.size(), r);
	endfunction

	function automatic void push_byte(input bit [7:0] b);
		request_t r;
		r      = '0;
		r.op   = OP_STREAM;
		r.data = b;
		r.idx  = 8'($urandom_range(0, 255));
		r.sz   = 16'($urandom_range(0, 65535));
		push(r);
	endfunction

	function automatic void push_write(input bit [7:0] idx, input bit [15:0] sz);
		request_t r;
		r      = '0;
		r.op   = OP_TABLE_WRITE;
		r.data = 8'($urandom_range(0, 255));
		r.idx  = idx;
		r.sz   = sz;
		push(r);
	endfunction

	// Mostly well-formed frames over a small opcode pool, with stray opcodes and table churn.
	function automatic void push_random(input int count);
		int       n;
		int       pick;
		bit [7:0] idx;
		n = 0;
		while (n < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				idx  = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 15))
				                                  : 8'($urandom_range(0, 255));
				pick = $urandom_range(0, 9);
				if (pick < 2) begin
					push_write(idx, '0);
				end else if (pick < 9) begin
					push_write(idx, 16'($urandom_range(1, 6)));
				end else begin
					push_write(idx, 16'($urandom_range(0, 65535)));
					push_write(idx, 16'($urandom_range(1, 6)));
					n++;
				end
			end else begin
				case (st[PLAN].phase)
					PH_LENGTH:
						push_byte(st[PLAN].gcount == 0 ? 8'($urandom_range(0, 20)) : 8'd0);
					PH_PAYLOAD:
						push_byte(8'($urandom_range(0, 255)));
					default: begin
						if (pick < 60)
							push_byte(8'($urandom_range(0, 15)));
						else if (pick < 73)
							push_byte(st[PLAN].var_op);
						else
							push_byte(8'($urandom_range(0, 255)));
					end
				endcase
			end
			n++;
		end
	endfunction

	task automatic drain();
		while (requests.size() != 0 || expected.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_variable_opcode(input bit [7:0] v);
		@(negedge clk);
		cfg_valid       <= 1'b1;
		variable_opcode <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		st[MODEL].var_op = v;
		st[PLAN].var_op  = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Hold a stalled request; otherwise present the next one or idle.
	always @(negedge clk) begin
		if (!in_valid || req_taken) begin
			req_taken = 1'b0;
			if (arst_n && requests.size() != 0 && !hold_off()) begin
				in_valid    <= 1'b1;
				operation   <= requests[0].op;
				data_byte   <= requests[0].data;
				entry_index <= requests[0].idx;
				entry_size  <= requests[0].sz;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= arst_n && hold_off();
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			frame_byte_t f;
			if (deframe(MODEL, requests[0], f))
				expected.insert(expected.size(), f);
			else
				table_writes++;
			requests.pop_front();
			req_taken = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			frame_byte_t want;
			if (expected.size() == 0) begin
				faults++;
				if (faults <= SHOWN_MISMATCHES)
					$display("unexpected result: byte %h role %0d opcode %h len %0d end %b",
					         out_byte, byte_role, frame_opcode, payload_length, frame_end);
			end else begin
				want = expected.pop_front();
				checked++;
				if (want.eof)
					frames_closed++;
				if (want.role == ROLE_DROPPED)
					dropped++;
				if (out_byte !== want.data || byte_role !== want.role
				    || frame_opcode !== want.opcode || payload_length !== want.plen
				    || frame_end !== want.eof) begin
					faults++;
					if (faults <= SHOWN_MISMATCHES)
						$display({"mismatch at result %0d: expected byte %h role %0d opcode %h",
						          " len %0d end %b, got byte %h role %0d opcode %h len %0d",
						          " end %b"}, checked, want.data, want.role, want.opcode,
						         want.plen, want.eof, out_byte, byte_role, frame_opcode,
						         payload_length, frame_end);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin : stimulus
		bit [7:0] settings [4];
		settings[0] = 8'd0;
		settings[1] = 8'd255;
		settings[2] = 8'($urandom_range(1, 254));
		settings[3] = VAR_OPCODE_RESET;
		clear_parser(MODEL);
		clear_parser(PLAN);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table: drop both extremes
		push_byte(8'h00);
		push_byte(8'hFF);
		push_write(8'hFF, 16'hFFFF);
		push_write(8'hFF, 16'd3);
		push_write(8'h00, 16'd1);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_write(8'h05, 16'd2);
		push_byte(8'h00);
		push_byte(8'hFF);
		// variable frames: empty payload, then two payload bytes
		push_write(VAR_OPCODE_RESET, 16'h8000);
		push_byte(VAR_OPCODE_RESET);
		repeat (4) push_byte(8'h00);
		push_byte(VAR_OPCODE_RESET);
		push_byte(8'h02);
		repeat (3) push_byte(8'h00);
		push_byte(8'hA5);
		push_byte(8'h5A);
		push_write(8'h00, 16'd0);
		push_byte(8'h00);
		push_byte(8'h05);
		push_byte(8'hC3);
		// leave a frame open across the first register write
		push_byte(8'hFF);

		for (int p = 0; p < 4; p++) begin
			drain();
			write_variable_opcode(settings[p]);
			push_write(settings[p], 16'($urandom_range(1, 65535)));
			calm = (p == 1);
			push_random(130);
		end
		drain();
		calm = 1'b0;
		repeat (8) @(posedge clk);
		faults += expected.size();

		$display("run covered %0d stream bytes (%0d frames closed, %0d opcodes dropped)",
		         checked, frames_closed, dropped);
		$display("plus %0d table writes under variable opcodes 63, %h, %h, %h, %h",
		         table_writes, settings[0], settings[1], settings[2], settings[3]);
		if (faults == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

>>> filelist.f
rtl/ostd_pkg.sv
rtl/ostd_ram.sv
rtl/ostd_lookup.sv
rtl/ostd_parser.sv
rtl/opcode_size_table_deframer.sv
tb/testbench.sv
